// ----- rtl/rgbkf_pkg.sv -----
// Package for the RGB 3x3 kernel filter: field widths, register indexes,
// filter kinds, the result record and the per-channel kernel arithmetic.
// No dependencies.
package rgbkf_pkg;

   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int SLOTS      = 4;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_FILTER_KIND  = 3'd2,
      CSR_SELECTION_ON = 3'd3,
      CSR_SEL_LEFT     = 3'd4,
      CSR_SEL_TOP      = 3'd5,
      CSR_SEL_RIGHT    = 3'd6,
      CSR_SEL_BOTTOM   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_GAUSS   = 2'd0,
      KIND_BOX     = 2'd1,
      KIND_SHARPEN = 2'd2,
      KIND_EDGE    = 2'd3
   } kind_type;

   // Kernel sums range from -2040 (edge) up to 4080 (gaussian)
   typedef logic signed [13:0] sum_type;

   // Four corners add to at most 1020, fits 10 bits
   typedef logic [9:0] part_type;

   // Reciprocal of 9 scaled by 2^15, exact for every box sum below 2^15
   localparam logic [11:0] RECIP_NINE = 12'd3641;
   localparam int          RECIP_SHIFT = 15;

   // One result record: up to four results caused by one input
   typedef struct packed {
      logic [SLOTS-1:0]                mask;
      logic [SLOTS-1:0][COORD_W-1:0]   row;
      logic [SLOTS-1:0][COORD_W-1:0]   col;
      logic [SLOTS-1:0][PIX_W-1:0]     pix;
   } rec_type;

   // Weighted sum of one channel: corners, edge neighbors and center
   // gaussian 1 2 1 / 2 4 2 / 1 2 1, box all ones,
   // sharpen 0 -1 0 / -1 5 -1 / 0 -1 0, edge -1 ... 8 ... -1
   function automatic sum_type kernel_sum(input kind_type kind, input part_type corners,
                                          input part_type edges, input logic [7:0] center);
      sum_type c_s;
      sum_type e_s;
      sum_type m_s;
      sum_type res;
      c_s = sum_type'(corners);
      e_s = sum_type'(edges);
      m_s = sum_type'(center);
      case (kind)
         KIND_GAUSS:   res = c_s + (e_s <<< 1) + (m_s <<< 2);
         KIND_BOX:     res = c_s + e_s + m_s;
         KIND_SHARPEN: res = (m_s <<< 2) + m_s - e_s;
         KIND_EDGE:    res = (m_s <<< 3) - c_s - e_s;
         default:      res = '0;
      endcase
      return res;
   endfunction

   // Round, scale and clamp one channel sum to 0..255
   function automatic logic [CHAN_W-1:0] finish_chan(input kind_type kind, input sum_type sum);
      logic [11:0]       biased;
      logic [23:0]       prod;
      logic [CHAN_W-1:0] res;
      biased = '0;
      prod   = '0;
      case (kind)
         KIND_GAUSS: begin
            biased = sum[11:0] + 12'd8;
            res    = biased[11:4];
         end
         KIND_BOX: begin
            biased = sum[11:0] + 12'd4;
            prod   = biased * RECIP_NINE;
            res    = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
         end
         default: begin
            if (sum < 0) begin
               res = '0;
            end else if (sum > sum_type'(255)) begin
               res = '1;
            end else begin
               res = sum[CHAN_W-1:0];
            end
         end
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/rgbkf_req_if.sv -----
// Input pixel channel of the RGB 3x3 kernel filter.
// Depends on rgbkf_pkg for the channel width.
interface rgbkf_req_if;
   import rgbkf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

// ----- rtl/rgbkf_rsp_if.sv -----
// Result channel of the RGB 3x3 kernel filter.
// Depends on rgbkf_pkg for the field widths.
interface rgbkf_rsp_if;
   import rgbkf_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_row;
   logic [COORD_W-1:0] out_col;
   logic [CHAN_W-1:0]  out_red;
   logic [CHAN_W-1:0]  out_green;
   logic [CHAN_W-1:0]  out_blue;
   logic               run_last;

   modport source (output valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   output ready);
endinterface

// ----- rtl/rgb_3x3_kernel_filter.sv -----
// RGB 3x3 kernel filter top level: line memory, window, kernel pipeline, result queue.
// Depends on rgbkf_pkg, rgbkf_req_if and rgbkf_rsp_if.
//
//   channel | direction | transfer when          | payload
//   req     | in        | req.valid & req.ready  | in_red, in_green, in_blue
//   rsp     | out       | rsp.valid & rsp.ready  | out_row, out_col, rgb, run_last
//   csr     | in        | csr_we                 | csr_index, csr_data
//
// One pixel per cycle enters; its results pass the pipeline registers and the result queue
// and leave on rsp, one result per cycle while rsp.ready is high. Inputs that raise up to
// four results (end of row, final row) give them one by one from one queue record; the input
// stalls when the queue credit (eight records less queued and pipelined ones) runs out.
// The line memory is a single 2-row-wide array read and written once per pixel.
// Reset is synchronous and clears counters, window, pipeline valids and the queue.
module rgb_3x3_kernel_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rgbkf_req_if.sink                       req,
   rgbkf_rsp_if.source                     rsp,
   input  logic                            csr_we,
   input  logic [rgbkf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rgbkf_pkg::CSR_DATA_W-1:0] csr_data
);
   import rgbkf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = ($clog2(MAX_WIDTH + 1) > CSR_DATA_W) ? $clog2(MAX_WIDTH + 1) : CSR_DATA_W;
   localparam int YW = ($clog2(MAX_HEIGHT + 1) > CSR_DATA_W) ? $clog2(MAX_HEIGHT + 1)
                                                              : CSR_DATA_W;
   localparam int DEPTH = 8;
   localparam int PW = $clog2(DEPTH);
   localparam int CNT_W = PW + 1;

   // Configuration registers
   logic [CSR_DATA_W-1:0] width_ff, height_ff, left_ff, top_ff, right_ff, bottom_ff;
   kind_type              kind_ff;
   logic                  sel_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(1024);
         height_ff <= CSR_DATA_W'(1024);
         kind_ff   <= KIND_GAUSS;
         sel_on_ff <= 1'b0;
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= CSR_DATA_W'(1024);
         bottom_ff <= CSR_DATA_W'(1024);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            CSR_FILTER_KIND:  kind_ff   <= kind_type'(csr_data[1:0]);
            CSR_SELECTION_ON: sel_on_ff <= csr_data[0];
            CSR_SEL_LEFT:     left_ff   <= csr_data;
            CSR_SEL_TOP:      top_ff    <= csr_data;
            CSR_SEL_RIGHT:    right_ff  <= csr_data;
            CSR_SEL_BOTTOM:   bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective image size, clamped to 3..MAX
   logic [XW-1:0] w_eff, width_x;
   logic [YW-1:0] h_eff, height_y;
   always_comb begin
      width_x  = XW'(width_ff);
      height_y = YW'(height_ff);
      if (width_x < XW'(3)) w_eff = XW'(3);
      else if (width_x > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
      else w_eff = width_x;
      if (height_y < YW'(3)) h_eff = YW'(3);
      else if (height_y > YW'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
      else h_eff = height_y;
   end

   // Stage valids and result queue credit
   logic             s1_v_ff, s2_v_ff, s3_v_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] used;
   logic             acc;

   assign used      = count_ff + CNT_W'(s1_v_ff) + CNT_W'(s2_v_ff) + CNT_W'(s3_v_ff);
   assign req.ready = (used < CNT_W'(DEPTH));
   assign acc       = req.valid & req.ready;

   // Position of this input and of the next one
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [XW-1:0] c0, cn;
   logic [YW-1:0] r0, rn;
   always_comb begin
      c0 = XW'(col_ff);
      r0 = YW'(row_ff);
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + YW'(1);
      end
      if (r0 >= h_eff) r0 = '0;
      cn = c0 + XW'(1);
      rn = r0;
      if (cn >= w_eff) begin
         cn = '0;
         rn = r0 + YW'(1);
         if (rn >= h_eff) rn = '0;
      end
      col_in = cn[AW-1:0];
      row_in = rn[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line memory: upper half two rows up, lower half one row up
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0]   s1_px_ff;
   logic [XW-1:0]      s1_c_ff;
   logic [YW-1:0]      s1_r_ff;

   always_ff @(posedge clock) begin
      if (acc) rd_ff <= line_mem[c0[AW-1:0]];
      if (s1_v_ff) line_mem[s1_c_ff[AW-1:0]] <= {rd_ff[PIX_W-1:0], s1_px_ff};
   end

   // Stage 1 registers: pixel and position
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= acc;
      if (acc) begin
         s1_px_ff <= {req.in_red, req.in_green, req.in_blue};
         s1_c_ff  <= c0;
         s1_r_ff  <= r0;
      end
   end

   // Shift the window and load the new column
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]   = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = rd_ff[2*PIX_W-1:PIX_W];
      win_in[5] = rd_ff[PIX_W-1:0];
      win_in[8] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (s1_v_ff) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
      end
   end

   // Result slots, selection test and positions
   logic [SLOTS-1:0]              mask1;
   logic                          use1, in_sel;
   logic [XW-1:0]                 x, x1, x2;
   logic [YW-1:0]                 y, y1, y2, hl;
   logic [XW-1:0]                 wl;
   logic [SLOTS-1:0][COORD_W-1:0] rows1, cols1;
   always_comb begin
      x  = s1_c_ff - XW'(1);
      y  = s1_r_ff - YW'(1);
      wl = w_eff - XW'(1);
      hl = h_eff - YW'(1);
      x1 = (left_ff == '0) ? XW'(1) : XW'(left_ff);
      y1 = (top_ff == '0) ? YW'(1) : YW'(top_ff);
      x2 = (XW'(right_ff) == w_eff) ? wl : XW'(right_ff);
      y2 = (YW'(bottom_ff) == h_eff) ? hl : YW'(bottom_ff);
      in_sel = (x >= x1) && (x < x2) && (y >= y1) && (y < y2);
      use1 = (s1_r_ff >= YW'(2)) && (s1_c_ff >= XW'(2)) && (!sel_on_ff || in_sel);
      mask1[0] = (s1_r_ff >= YW'(1)) && (s1_c_ff >= XW'(1));
      mask1[1] = (s1_r_ff >= YW'(1)) && (s1_c_ff == wl);
      mask1[2] = (s1_r_ff == hl) && (s1_c_ff >= XW'(1));
      mask1[3] = (s1_r_ff == hl) && (s1_c_ff == wl);
      rows1[0] = y[COORD_W-1:0];
      cols1[0] = x[COORD_W-1:0];
      rows1[1] = y[COORD_W-1:0];
      cols1[1] = wl[COORD_W-1:0];
      rows1[2] = hl[COORD_W-1:0];
      cols1[2] = x[COORD_W-1:0];
      rows1[3] = hl[COORD_W-1:0];
      cols1[3] = wl[COORD_W-1:0];
   end

   // Stage 2 registers: window snapshot and slot data
   logic [PIX_W-1:0]              s2_win_ff [9];
   logic [SLOTS-1:0]              s2_mask_ff;
   logic                          s2_use_ff;
   logic [SLOTS-1:0][COORD_W-1:0] s2_rows_ff, s2_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      if (s1_v_ff) begin
         for (int i = 0; i < 9; i++) s2_win_ff[i] <= win_in[i];
         s2_mask_ff <= mask1;
         s2_use_ff  <= use1;
         s2_rows_ff <= rows1;
         s2_cols_ff <= cols1;
      end
   end

   // Channel sums of the kernel
   sum_type  sum2 [3];
   part_type corners, edges;
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         corners = part_type'(s2_win_ff[0][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[2][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[6][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[8][ch*CHAN_W +: CHAN_W]);
         edges   = part_type'(s2_win_ff[1][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[3][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[5][ch*CHAN_W +: CHAN_W])
                 + part_type'(s2_win_ff[7][ch*CHAN_W +: CHAN_W]);
         sum2[ch] = kernel_sum(kind_ff, corners, edges, s2_win_ff[4][ch*CHAN_W +: CHAN_W]);
      end
   end

   // Stage 3 registers: sums and pass-through pixels
   sum_type                       s3_sum_ff [3];
   logic [SLOTS-1:0][PIX_W-1:0]   s3_pass_ff;
   logic [SLOTS-1:0]              s3_mask_ff;
   logic                          s3_use_ff;
   logic [SLOTS-1:0][COORD_W-1:0] s3_rows_ff, s3_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      if (s2_v_ff) begin
         for (int ch = 0; ch < 3; ch++) s3_sum_ff[ch] <= sum2[ch];
         s3_pass_ff <= {s2_win_ff[8], s2_win_ff[7], s2_win_ff[5], s2_win_ff[4]};
         s3_mask_ff <= s2_mask_ff;
         s3_use_ff  <= s2_use_ff;
         s3_rows_ff <= s2_rows_ff;
         s3_cols_ff <= s2_cols_ff;
      end
   end

   // Finish the channels and build the record
   rec_type          rec3;
   logic [PIX_W-1:0] filt;
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         filt[ch*CHAN_W +: CHAN_W] = finish_chan(kind_ff, s3_sum_ff[ch]);
      end
      rec3.mask   = s3_mask_ff;
      rec3.row    = s3_rows_ff;
      rec3.col    = s3_cols_ff;
      rec3.pix    = s3_pass_ff;
      if (s3_use_ff) rec3.pix[0] = filt;
   end

   // Result queue
   rec_type          fifo_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [SLOTS-1:0] sent_ff;
   logic             push, pop, out_xfer, last;
   logic [SLOTS-1:0] avail, pick;
   logic [1:0]       sel;
   rec_type          head;

   assign head = fifo_ff[rp_ff];
   assign push = s3_v_ff && (rec3.mask != '0);

   always_comb begin
      avail = head.mask & ~sent_ff;
      sel   = 2'd0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (avail[s]) sel = 2'(s);
      end
      pick = SLOTS'(1) << sel;
      last = ((avail & ~pick) == '0);
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.out_row   = head.row[sel];
   assign rsp.out_col   = head.col[sel];
   assign rsp.out_red   = head.pix[sel][2*CHAN_W +: CHAN_W];
   assign rsp.out_green = head.pix[sel][CHAN_W +: CHAN_W];
   assign rsp.out_blue  = head.pix[sel][0 +: CHAN_W];
   assign rsp.run_last  = last;
   assign out_xfer      = rsp.valid & rsp.ready;
   assign pop           = out_xfer & last;

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wp_ff] <= rec3;
   end

   // Advance pointers, count and sent slots
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
         sent_ff  <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (pop) rp_ff <= rp_ff + PW'(1);
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
         if (pop) sent_ff <= '0;
         else if (out_xfer) sent_ff <= sent_ff | pick;
      end
   end

endmodule
